/* rtl/rvrd_pkg.sv */
// Package for the raw-video RTP depacketizer: shared types, register indexes and constants.
// No dependencies; every other file of the block but rvrd_chan_if imports it.
`default_nettype none
package rvrd_pkg;

   localparam int MAX_SRDS_DEFAULT = 3;
   localparam int QUEUE_DEPTH      = 8;
   localparam int SRD_IDX_W        = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_LINE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_PIXEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_PER_SRD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_MODE      = 3'd4;

   localparam logic [1:0] SCAN_PROGRESSIVE = 2'd0;
   localparam logic [1:0] SCAN_EVEN_FIRST  = 2'd1;
   localparam logic [1:0] SCAN_ODD_FIRST   = 2'd2;
   localparam logic [1:0] SCAN_PSF         = 2'd3;

   localparam logic [1:0] PH_SEQ  = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   localparam int SEQ_BYTES     = 2;
   localparam int SRD_HDR_BYTES = 6;

   // Division by three of a value below 2^16 by reciprocal multiplication.
   localparam logic [16:0] DIV3_RECIP = 17'd43691;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] payload_length;
      logic        last_in_packet;
   } req_payload_type;

   typedef struct packed {
      logic [30:0] write_address;
      logic [7:0]  write_data;
   } rsp_payload_type;

   typedef struct packed {
      logic                 valid;
      logic                 bank;
      logic [SRD_IDX_W-1:0] idx;
      logic [15:0]          len;
      logic [14:0]          row;
      logic                 fbit;
      logic [14:0]          offset;
   } srd_job_type;

   typedef struct packed {
      logic                 valid;
      logic                 bank;
      logic [SRD_IDX_W-1:0] idx;
      logic [30:0]          base;
      logic                 ok;
   } srd_res_type;

   typedef struct packed {
      logic [7:0]           data;
      logic                 bank;
      logic [SRD_IDX_W-1:0] idx;
      logic                 first;
   } qent_type;

   // Row count divided by the rows per wire row (1, 2 or 3).
   function automatic logic [14:0] div_rows(input logic [14:0] x, input logic [1:0] rps);
      logic [31:0] prod;
      prod = {17'd0, x} * {15'd0, DIV3_RECIP};
      case (rps)
         2'd2:    div_rows = {1'b0, x[14:1]};
         2'd3:    div_rows = prod[31:17];
         default: div_rows = x;
      endcase
   endfunction

endpackage
`default_nettype wire

/* rtl/rvrd_chan_if.sv */
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none
interface rvrd_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/raw_video_rtp_depacketizer.sv */
// Raw-video RTP depacketizer. Accepts one payload byte per cycle, back to back, while
// the queue has room and no header byte waits on a busy bank. A data byte is queued
// when accepted and leaves through the writer's output register; the first byte of a
// segment may wait for the five-stage address unit, and bytes queued behind it wait too.
// Throughput is one byte per cycle unless stalled; the queue absorbs the address delay.
// Synchronous active-high reset clears all control state and restores register defaults.
`default_nettype none
module raw_video_rtp_depacketizer #(
   parameter int MAX_SRDS    = rvrd_pkg::MAX_SRDS_DEFAULT,
   parameter int QUEUE_DEPTH = rvrd_pkg::QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rvrd_chan_if.sink                             req_if,
   rvrd_chan_if.source                           rsp_if,
   input  wire logic                             csr_write_enable,
   input  wire logic [rvrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rvrd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rvrd_pkg::*;

   // The front end parses headers and tags each data byte with its segment.
   // Segment records alternate between two banks from packet to packet, so
   // the writer can still be draining one packet while the next is parsed.
   // The front end holds off header parsing while its bank still has bytes
   // queued, which keeps base addresses from being overwritten in use.

   logic          push;
   qent_type      push_entry;
   logic          queue_ready;
   logic [1:0]    bank_busy;
   logic          pop;
   qent_type      head;
   logic          not_empty;
   srd_job_type   job;
   srd_res_type   res;

   rvrd_front #(.MAX_SRDS(MAX_SRDS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .queue_ready (queue_ready),
      .bank_busy   (bank_busy),
      .push        (push),
      .push_entry  (push_entry),
      .job         (job)
   );

   // Address unit: wire row, pixel-to-byte offset and the frame-end check.
   rvrd_addr u_addr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .job              (job),
      .res              (res)
   );

   rvrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .ready      (queue_ready),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .bank_busy  (bank_busy)
   );

   // The writer drops bytes of segments that would pass the frame end.
   rvrd_back #(.MAX_SRDS(MAX_SRDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .rsp_if    (rsp_if),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .job       (job),
      .res       (res)
   );

endmodule
`default_nettype wire

/* rtl/rvrd_front.sv */
// Front end: accepts payload bytes, walks the sequence number and SRD headers,
// tracks segments and queues data bytes. Depends on rvrd_pkg and rvrd_chan_if.
`default_nettype none
module rvrd_front #(
   parameter int MAX_SRDS = rvrd_pkg::MAX_SRDS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rvrd_chan_if.sink                 req_if,
   input  wire logic                 queue_ready,
   input  wire logic [1:0]           bank_busy,
   output logic                      push,
   output rvrd_pkg::qent_type        push_entry,
   output rvrd_pkg::srd_job_type     job
);
   import rvrd_pkg::*;

   localparam int CNT_W = $clog2(MAX_SRDS + 1);
   localparam int REC_W = (MAX_SRDS > 1) ? $clog2(MAX_SRDS) : 1;

   localparam logic [2:0] HB_LEN_HI = 3'd0;
   localparam logic [2:0] HB_LEN_LO = 3'd1;
   localparam logic [2:0] HB_ROW_HI = 3'd2;
   localparam logic [2:0] HB_ROW_LO = 3'd3;
   localparam logic [2:0] HB_OFF_HI = 3'd4;
   localparam logic [2:0] HB_OFF_LO = 3'd5;

   logic [15:0]      pos_ff, pos_in;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       k_ff, k_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [15:0]      left_ff, left_in;
   logic             cont_ff, cont_in;
   logic             stop_ff, stop_in;
   logic             first_ff, first_in;
   logic             bank_ff, bank_in;
   logic [15:0]      wlen_ff, wlen_in;
   logic [14:0]      wrow_ff, wrow_in;
   logic             wfbit_ff, wfbit_in;
   logic [14:0]     woff_ff, woff_in;
   logic [15:0]      len_ff [MAX_SRDS];
   logic             rec_we;
   srd_job_type      job_ff, job_in;

   logic             fire;
   logic             active;
   logic [7:0]       b;
   logic [15:0]      plen;
   logic [16:0]      cursor;
   logic [CNT_W-1:0] o_s0, o_total;
   logic [15:0]      o_lens [MAX_SRDS];
   logic             o_done, o_found;
   logic [CNT_W-1:0] o_sel;
   logic [15:0]      o_len;
   logic             more;
   logic [15:0]      left_dec;

   assign b      = req_if.payload.payload_byte;
   assign plen   = req_if.payload.payload_length;
   assign cursor = {1'b0, pos_ff} + 17'd1;
   assign req_if.ready = queue_ready && !((phase_ff == PH_HDR) && bank_busy[bank_ff]);
   assign fire   = req_if.valid && req_if.ready;
   assign active = !stop_ff && (pos_ff < plen);
   assign job    = job_ff;

   // Search for the next segment that carries data, starting at o_s0.
   always_comb begin
      o_s0    = (phase_ff == PH_HDR) ? '0 : cur_ff + CNT_W'(1);
      o_total = (phase_ff == PH_HDR) ? total_ff + CNT_W'(1) : total_ff;
      for (int i = 0; i < MAX_SRDS; i++) begin
         o_lens[i] = ((phase_ff == PH_HDR) && (total_ff == CNT_W'(i))) ? wlen_ff : len_ff[i];
      end
      o_done  = 1'b0;
      o_found = 1'b0;
      o_sel   = '0;
      o_len   = '0;
      for (int i = 0; i < MAX_SRDS; i++) begin
         if (!o_done && (CNT_W'(i) >= o_s0) && (CNT_W'(i) < o_total)) begin
            if (({1'b0, cursor} + {2'b0, o_lens[i]}) > {2'b0, plen}) begin
               o_done = 1'b1;
            end else if (o_lens[i] != 16'd0) begin
               o_found = 1'b1;
               o_done  = 1'b1;
               o_sel   = CNT_W'(i);
               o_len   = o_lens[i];
            end
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      total_in = total_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      cont_in  = cont_ff;
      stop_in  = stop_ff;
      first_in = first_ff;
      bank_in  = bank_ff;
      wlen_in  = wlen_ff;
      wrow_in  = wrow_ff;
      wfbit_in = wfbit_ff;
      woff_in  = woff_ff;
      rec_we   = 1'b0;
      job_in   = job_ff;
      job_in.valid = 1'b0;
      push     = 1'b0;
      push_entry.data  = b;
      push_entry.bank  = bank_ff;
      push_entry.idx   = SRD_IDX_W'(cur_ff);
      push_entry.first = first_ff;
      more     = 1'b0;
      left_dec = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;

      if (fire) begin
         if ((phase_ff == PH_HDR) && (pos_ff != 16'hFFFF)) begin
            k_in = (k_ff == HB_OFF_LO) ? HB_LEN_HI : k_ff + 3'd1;
         end
         if (active) begin
            case (phase_ff)
               PH_SEQ: begin
                  if (pos_ff != 16'd0) begin
                     if (plen >= 16'(SEQ_BYTES + SRD_HDR_BYTES)) begin
                        phase_in = PH_HDR;
                        total_in = '0;
                        k_in     = HB_LEN_HI;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               PH_HDR: begin
                  if (total_ff >= CNT_W'(MAX_SRDS)) begin
                     stop_in = 1'b1;
                  end else begin
                     case (k_ff)
                        HB_LEN_HI: wlen_in = {b, 8'h00};
                        HB_LEN_LO: wlen_in = wlen_ff | {8'h00, b};
                        HB_ROW_HI: begin
                           wfbit_in = b[7];
                           wrow_in  = {b[6:0], 8'h00};
                        end
                        HB_ROW_LO: wrow_in = wrow_ff | {7'h00, b};
                        HB_OFF_HI: begin
                           cont_in = b[7];
                           woff_in = {b[6:0], 8'h00};
                        end
                        HB_OFF_LO: begin
                           rec_we        = 1'b1;
                           job_in.valid  = 1'b1;
                           job_in.bank   = bank_ff;
                           job_in.idx    = SRD_IDX_W'(total_ff);
                           job_in.len    = wlen_ff;
                           job_in.row    = wrow_ff;
                           job_in.fbit   = wfbit_ff;
                           job_in.offset = woff_ff | {7'h00, b};
                           total_in      = total_ff + CNT_W'(1);
                           more = cont_ff && ((total_ff + CNT_W'(1)) < CNT_W'(MAX_SRDS))
                                  && (({1'b0, cursor} + 18'(SRD_HDR_BYTES)) <= {2'b0, plen});
                           cont_in  = 1'b0;
                           wlen_in  = '0;
                           wrow_in  = '0;
                           wfbit_in = 1'b0;
                           woff_in  = '0;
                           if (!more) begin
                              cur_in = '0;
                              if (o_found) begin
                                 left_in  = o_len;
                                 phase_in = PH_DATA;
                                 cur_in   = o_sel;
                                 first_in = 1'b1;
                              end else begin
                                 stop_in = 1'b1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               PH_DATA: begin
                  push     = 1'b1;
                  first_in = 1'b0;
                  left_in  = left_dec;
                  if (left_dec == 16'd0) begin
                     cont_in = 1'b0;
                     cur_in  = cur_ff + CNT_W'(1);
                     if (o_found) begin
                        left_in  = o_len;
                        phase_in = PH_DATA;
                        cur_in   = o_sel;
                        first_in = 1'b1;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
         if (req_if.payload.last_in_packet) begin
            pos_in   = '0;
            phase_in = PH_SEQ;
            k_in     = HB_LEN_HI;
            total_in = '0;
            cur_in   = '0;
            left_in  = '0;
            cont_in  = 1'b0;
            stop_in  = 1'b0;
            first_in = 1'b0;
            wlen_in  = '0;
            wrow_in  = '0;
            wfbit_in = 1'b0;
            woff_in  = '0;
            bank_in  = ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_SEQ;
         k_ff         <= HB_LEN_HI;
         total_ff     <= '0;
         cur_ff       <= '0;
         left_ff      <= '0;
         cont_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         first_ff     <= 1'b0;
         bank_ff      <= 1'b0;
         wlen_ff      <= '0;
         wrow_ff      <= '0;
         wfbit_ff     <= 1'b0;
         woff_ff      <= '0;
         job_ff.valid <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         total_ff <= total_in;
         cur_ff   <= cur_in;
         left_ff  <= left_in;
         cont_ff  <= cont_in;
         stop_ff  <= stop_in;
         first_ff <= first_in;
         bank_ff  <= bank_in;
         wlen_ff  <= wlen_in;
         wrow_ff  <= wrow_in;
         wfbit_ff <= wfbit_in;
         woff_ff  <= woff_in;
         job_ff   <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         len_ff[REC_W'(total_ff)] <= wlen_ff;
      end
   end

endmodule
`default_nettype wire

/* rtl/rvrd_addr.sv */
// Configuration registers and the pipelined SRD address unit, which turns a
// parsed header into a base byte address and an in-frame flag. Depends on rvrd_pkg.
`default_nettype none
module rvrd_addr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rvrd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rvrd_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire rvrd_pkg::srd_job_type                job,
   output rvrd_pkg::srd_res_type                     res
);
   import rvrd_pkg::*;

   logic [15:0] bpl_ff;
   logic [6:0]  bpp_ff;
   logic [14:0] fh_ff;
   logic [1:0]  rps_ff;
   logic [1:0]  scan_ff;

   logic [1:0]  rps_eff;
   logic [14:0] wrows_ff;
   logic [30:0] frame_ff;
   logic [14:0] half_ff;
   logic        split_ff;
   logic [15:0] half_sum;

   srd_job_type j2_ff, j3_ff, j4_ff, j5_ff;
   logic [15:0] wrow_in, wrow_ff;
   logic [21:0] prod_in, prod_ff;
   logic [31:0] rowb_ff;
   logic [18:0] boff_ff;
   logic [32:0] dst_ff;
   srd_res_type res_ff;
   logic        par;

   assign rps_eff  = (rps_ff == 2'd0) ? 2'd1 : rps_ff;
   assign half_sum = {1'b0, wrows_ff} + 16'd1;
   assign res      = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff  <= 16'd3840;
         bpp_ff  <= 7'd16;
         fh_ff   <= 15'd1080;
         rps_ff  <= 2'd1;
         scan_ff <= SCAN_PROGRESSIVE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BYTES_PER_LINE: bpl_ff  <= csr_write_data[15:0];
            CSR_BITS_PER_PIXEL: bpp_ff  <= csr_write_data[6:0];
            CSR_FRAME_HEIGHT:   fh_ff   <= csr_write_data[14:0];
            CSR_ROWS_PER_SRD:   rps_ff  <= csr_write_data[1:0];
            CSR_SCAN_MODE:      scan_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Frame geometry is registered from the configuration registers, via the wire-row count.
   always_ff @(posedge clock) begin
      wrows_ff <= div_rows(fh_ff, rps_eff);
      frame_ff <= 31'({16'd0, bpl_ff} * {17'd0, wrows_ff});
      half_ff  <= half_sum[15:1];
      split_ff <= (scan_ff != SCAN_PROGRESSIVE) && (rps_eff <= 2'd1);
   end

   always_comb begin
      par = j2_ff.fbit ^ (scan_ff == SCAN_ODD_FIRST);
      if (!split_ff) begin
         wrow_in = {1'b0, div_rows(j2_ff.row, rps_eff)};
      end else if ((scan_ff == SCAN_EVEN_FIRST) || (scan_ff == SCAN_ODD_FIRST)) begin
         wrow_in = {j2_ff.row, par};
      end else if (j2_ff.fbit) begin
         wrow_in = {1'b0, half_ff} + {1'b0, j2_ff.row};
      end else begin
         wrow_in = {1'b0, j2_ff.row};
      end
      prod_in = {7'd0, j2_ff.offset} * {15'd0, bpp_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j2_ff.valid  <= 1'b0;
         j3_ff.valid  <= 1'b0;
         j4_ff.valid  <= 1'b0;
         j5_ff.valid  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         j2_ff        <= job;
         j3_ff        <= j2_ff;
         j4_ff        <= j3_ff;
         j5_ff        <= j4_ff;
         res_ff.valid <= j5_ff.valid;
      end
      wrow_ff    <= wrow_in;
      prod_ff    <= prod_in;
      rowb_ff    <= {16'd0, wrow_ff} * {16'd0, bpl_ff};
      boff_ff    <= prod_ff[21:3];
      dst_ff     <= {1'b0, rowb_ff} + {14'd0, boff_ff};
      res_ff.bank <= j5_ff.bank;
      res_ff.idx  <= j5_ff.idx;
      res_ff.base <= dst_ff[30:0];
      res_ff.ok   <= ({1'b0, dst_ff} + {18'd0, j5_ff.len}) <= {3'd0, frame_ff};
   end

endmodule
`default_nettype wire

/* rtl/rvrd_queue.sv */
// Short queue of data bytes between the front end and the writer, with a
// count of queued bytes per segment bank. Depends on rvrd_pkg.
`default_nettype none
module rvrd_queue #(
   parameter int DEPTH = rvrd_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rvrd_pkg::qent_type   push_entry,
   output logic                      ready,
   input  wire logic                 pop,
   output rvrd_pkg::qent_type        head,
   output logic                      not_empty,
   output logic [1:0]                bank_busy
);
   import rvrd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qent_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] busy_ff [2];

   assign ready        = count_ff < CNT_W'(DEPTH);
   assign not_empty    = count_ff != '0;
   assign head         = mem_ff[rd_ff];
   assign bank_busy[0] = busy_ff[0] != '0;
   assign bank_busy[1] = busy_ff[1] != '0;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff      <= '0;
         rd_ff      <= '0;
         count_ff   <= '0;
         busy_ff[0] <= '0;
         busy_ff[1] <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
         for (int i = 0; i < 2; i++) begin
            busy_ff[i] <= busy_ff[i] + CNT_W'(push && (push_entry.bank == 1'(i)))
                          - CNT_W'(pop && (head.bank == 1'(i)));
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/rvrd_back.sv */
// Writer: holds the segment base addresses, drains the queue and drives the
// write channel through an output register. Depends on rvrd_pkg and rvrd_chan_if.
`default_nettype none
module rvrd_back #(
   parameter int MAX_SRDS = rvrd_pkg::MAX_SRDS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rvrd_chan_if.source               rsp_if,
   input  wire rvrd_pkg::qent_type   head,
   input  wire logic                 not_empty,
   output logic                      pop,
   input  wire rvrd_pkg::srd_job_type job,
   input  wire rvrd_pkg::srd_res_type res
);
   import rvrd_pkg::*;

   localparam int REC_W = (MAX_SRDS > 1) ? $clog2(MAX_SRDS) : 1;

   logic [30:0] base_ff [2][MAX_SRDS];
   logic        sok_ff  [2][MAX_SRDS];
   logic        svld_ff [2][MAX_SRDS];

   logic        out_valid_ff;
   logic [30:0] out_addr_ff;
   logic [7:0]  out_data_ff;
   logic [30:0] ptr_ff;
   logic        okc_ff;

   logic [REC_W-1:0] hidx;
   logic             slot_ok;
   logic [30:0]      slot_base;
   logic             cur_ok;
   logic [30:0]      cur_addr;

   assign hidx      = REC_W'(head.idx);
   assign slot_ok   = sok_ff[head.bank][hidx];
   assign slot_base = base_ff[head.bank][hidx];
   assign pop       = not_empty && (!head.first || svld_ff[head.bank][hidx])
                      && (!out_valid_ff || rsp_if.ready);
   assign cur_ok    = head.first ? slot_ok : okc_ff;
   assign cur_addr  = head.first ? slot_base : ptr_ff;

   assign rsp_if.valid                 = out_valid_ff;
   assign rsp_if.payload.write_address = out_addr_ff;
   assign rsp_if.payload.write_data    = out_data_ff;

   always_ff @(posedge clock) begin
      if (res.valid) begin
         base_ff[res.bank][REC_W'(res.idx)] <= res.base;
         sok_ff[res.bank][REC_W'(res.idx)]  <= res.ok;
      end
      if (pop) begin
         out_addr_ff <= cur_addr;
         out_data_ff <= head.data;
         ptr_ff      <= cur_addr + 31'd1;
         okc_ff      <= cur_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < MAX_SRDS; j++) begin
               svld_ff[i][j] <= 1'b0;
            end
         end
      end else begin
         if (pop) begin
            out_valid_ff <= cur_ok;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (job.valid) begin
            svld_ff[job.bank][REC_W'(job.idx)] <= 1'b0;
         end
         if (res.valid) begin
            svld_ff[res.bank][REC_W'(res.idx)] <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

/* tb/raw_video_rtp_depacketizer_tb.sv */
// Self-checking testbench for the raw-video RTP depacketizer: directed packets, then random
// packets under several register settings. Depends on rvrd_pkg, rvrd_chan_if and the block.
`default_nettype none
module raw_video_rtp_depacketizer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rvrd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TARGET_ITEMS   = 1150;
   localparam int DRAIN_CYCLES   = 20;
   localparam int NUM_PHASES     = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   rvrd_chan_if #(.payload_type(req_payload_type)) req_if ();
   rvrd_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   raw_video_rtp_depacketizer dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the registers, as the block should hold them.
   int unsigned line_bytes, pixel_bits, image_rows, rows_per_wire, scan_sel;

   // Shadow copy of the per-packet parse state.
   int unsigned pos_count, phase_now, hdr_count, hdr_index, remaining;
   logic [31:0] dest_addr;
   bit          copying, stopped;
   int unsigned hdr_len[3], hdr_row[3], hdr_field[3], hdr_offset[3];

   // Writes still owed by the block, oldest first.
   rsp_payload_type pending_writes[$];

   int unsigned mismatch_count = 0;
   int unsigned requests_sent = 0, writes_seen = 0, packets_sent = 0, idle_cycles = 0;
   bit          quiet = 1'b0;       // no idling on either side in the closing part

   // Directed rows carry their own expected write; the predictor's result is ignored for them.
   bit              use_typed = 1'b0;
   bit              typed_has_write;
   rsp_payload_type typed_write;

   function automatic void clear_packet_state();
      pos_count = 0;
      phase_now = PH_SEQ;
      hdr_count = 0;
      hdr_index = 0;
      remaining = 0;
      dest_addr = '0;
      copying   = 1'b0;
      stopped   = 1'b0;
   endfunction

   // Moves on to the next header that has data, working out where its bytes land.
   function automatic void open_next_segment(int unsigned cursor, int unsigned plen);
      int unsigned rps;
      longint unsigned frame_lines, frame_bytes, line_no, dst;
      bit split;
      rps = (rows_per_wire == 0) ? 1 : rows_per_wire;
      frame_lines = image_rows / rps;
      frame_bytes = longint'(line_bytes) * frame_lines;
      split = (scan_sel != SCAN_PROGRESSIVE) && (rps <= 1);
      while (hdr_index < hdr_count && hdr_index < 3) begin
         if (longint'(cursor) + hdr_len[hdr_index] > plen) begin
            stopped = 1'b1;
            return;
         end
         if (hdr_len[hdr_index] == 0) begin
            hdr_index++;
            continue;
         end
         if (!split) begin
            line_no = hdr_row[hdr_index] / rps;
         end else if (scan_sel == SCAN_EVEN_FIRST || scan_sel == SCAN_ODD_FIRST) begin
            int unsigned first_par, par;
            first_par = (scan_sel == SCAN_ODD_FIRST) ? 1 : 0;
            par = (hdr_field[hdr_index] == 0) ? first_par : 1 - first_par;
            line_no = longint'(hdr_row[hdr_index]) * 2 + par;
         end else begin
            line_no = (hdr_field[hdr_index] == 0) ? longint'(hdr_row[hdr_index])
                      : (frame_lines + 1) / 2 + hdr_row[hdr_index];
         end
         dst = line_no * line_bytes + (longint'(hdr_offset[hdr_index]) * pixel_bits) / 8;
         copying = (dst + hdr_len[hdr_index] <= frame_bytes);
         dest_addr = copying ? dst[31:0] : '0;
         remaining = hdr_len[hdr_index];
         phase_now = PH_DATA;
         return;
      end
      stopped = 1'b1;
   endfunction

   // Advances the shadow state by one payload byte; returns 1 when a write is due.
   function automatic bit predict_write(input req_payload_type r, output rsp_payload_type w);
      int unsigned b, plen, k;
      bit got, more;
      b = r.payload_byte;
      plen = r.payload_length;
      got = 1'b0;
      w = '0;
      if (!stopped && pos_count < plen) begin
         if (phase_now == PH_SEQ) begin
            if (pos_count + 1 >= SEQ_BYTES) begin
               if (SEQ_BYTES + SRD_HDR_BYTES <= plen) begin
                  phase_now = PH_HDR;
                  hdr_count = 0;
               end else begin
                  stopped = 1'b1;
               end
            end
         end else if (phase_now == PH_HDR) begin
            k = (pos_count - SEQ_BYTES) % SRD_HDR_BYTES;
            if (hdr_count >= 3) begin
               stopped = 1'b1;
            end else begin
               case (k)
                  0: hdr_len[hdr_count] = b << 8;
                  1: hdr_len[hdr_count] |= b;
                  2: begin
                     hdr_field[hdr_count] = b[7];
                     hdr_row[hdr_count] = (b & 8'h7F) << 8;
                  end
                  3: hdr_row[hdr_count] |= b;
                  4: begin
                     copying = b[7];
                     hdr_offset[hdr_count] = (b & 8'h7F) << 8;
                  end
                  default: begin
                     hdr_offset[hdr_count] |= b;
                     hdr_count++;
                     more = copying && hdr_count < 3
                            && pos_count + 1 + SRD_HDR_BYTES <= plen;
                     copying = 1'b0;
                     if (!more) begin
                        hdr_index = 0;
                        open_next_segment(pos_count + 1, plen);
                     end
                  end
               endcase
            end
         end else begin
            if (copying) begin
               w.write_address = dest_addr[30:0];
               w.write_data = r.payload_byte;
               got = 1'b1;
            end
            dest_addr++;
            if (remaining > 0) remaining--;
            if (remaining == 0) begin
               copying = 1'b0;
               hdr_index++;
               open_next_segment(pos_count + 1, plen);
            end
         end
      end
      if (pos_count < 16'hFFFF) pos_count++;
      if (r.last_in_packet) clear_packet_state();
      return got;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 30) $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Watches both channels: checks writes against the oldest expectation and
   // predicts for every request taken. Writes are checked first; none can come
   // from a request taken in the same cycle.
   int unsigned stuck_cycles = 0;
   always @(posedge clock) begin
      rsp_payload_type w, e;
      bit got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            w = rsp_if.payload;
            writes_seen++;
            if (pending_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write addr=%0h data=%0h",
                                         w.write_address, w.write_data));
            end else begin
               e = pending_writes.pop_front();
               if (w.write_address !== e.write_address)
                  report_mismatch($sformatf("write_address %0h, expected %0h",
                                            w.write_address, e.write_address));
               if (w.write_data !== e.write_data)
                  report_mismatch($sformatf("write_data %0h, expected %0h at %0h",
                                            w.write_data, e.write_data, e.write_address));
            end
         end
         if (req_if.valid && req_if.ready) begin
            got = predict_write(req_if.payload, w);
            if (use_typed) begin
               if (typed_has_write) pending_writes.push_back(typed_write);
            end else if (got) begin
               pending_writes.push_back(w);
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // The receiver stalls in short random bursts, never in the closing part.
   int unsigned stall_left = 0;
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_if.ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= (stall_left == 0);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[15:0];
      case (idx)
         CSR_BYTES_PER_LINE: line_bytes = value & 16'hFFFF;
         CSR_BITS_PER_PIXEL: pixel_bits = value & 7'h7F;
         CSR_FRAME_HEIGHT:   image_rows = value & 15'h7FFF;
         CSR_ROWS_PER_SRD:   rows_per_wire = value & 2'h3;
         CSR_SCAN_MODE:      scan_sel = value & 2'h3;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Offers one request and holds it until taken, then sometimes idles a little.
   task automatic send_request(input logic [7:0] b, input logic [15:0] plen, input bit last);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.payload <= '{payload_byte: b, payload_length: plen, last_in_packet: last};
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      requests_sent++;
      if (last) packets_sent++;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 3);
         idle_cycles += gap;
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits until every owed write has come, then lets the pipeline settle.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One random packet: mostly well formed with random content, some broken or noise.
   task automatic send_random_packet();
      logic [7:0] bytes[$];
      int unsigned nsrd, seg_len, row_max, plen, style;
      logic [15:0] len_field, row_field, off_field;
      bytes = {};
      style = $urandom_range(0, 19);
      if (style == 0) begin
         // noise: random bytes against a random length
         repeat ($urandom_range(1, 10)) bytes.push_back(8'($urandom_range(0, 255)));
         plen = $urandom_range(0, 16'hFFFF);
      end else begin
         bytes.push_back(8'($urandom_range(0, 255)));
         bytes.push_back(8'($urandom_range(0, 255)));
         nsrd = $urandom_range(1, 3);
         row_max = (image_rows == 0) ? 0 : image_rows - 1;
         for (int i = 0; i < nsrd; i++) begin
            seg_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            len_field = 16'(seg_len);
            row_field = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'h7FFF))
                        : 16'($urandom_range(0, row_max));
            off_field = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'h7FFF))
                        : 16'($urandom_range(0, 40));
            row_field[15] = 1'($urandom_range(0, 1));
            // continuation set on all but the last header, now and then wrong
            off_field[15] = (i != nsrd - 1) ^ ($urandom_range(0, 15) == 0);
            bytes.push_back(len_field[15:8]);
            bytes.push_back(len_field[7:0]);
            bytes.push_back(row_field[15:8]);
            bytes.push_back(row_field[7:0]);
            bytes.push_back(off_field[15:8]);
            bytes.push_back(off_field[7:0]);
         end
         for (int i = 0; i < nsrd; i++)
            repeat ($urandom_range(0, 24)) bytes.push_back(8'($urandom_range(0, 255)));
         plen = bytes.size();
         if (style == 1) plen = $urandom_range(0, plen);          // overrun
         if (style == 2) repeat (3) bytes.push_back(8'($urandom_range(0, 255))); // extra
         if (style == 3) plen = plen + $urandom_range(1, 40);     // short of the length
      end
      foreach (bytes[i]) begin
         send_request(bytes[i], plen[15:0], i == bytes.size() - 1);
      end
   endtask

   typedef struct {
      logic [7:0]  b;
      logic [15:0] plen;
      bit          last;
      bit          has_write;
      logic [30:0] addr;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void add_row(logic [7:0] b, logic [15:0] plen, bit last,
                                   bit has_write = 0, logic [30:0] addr = 0);
      dir_rows.push_back('{b, plen, last, has_write, addr});
   endfunction

   initial begin
      int unsigned phase_goal;
      int unsigned random_base;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      line_bytes = 3840; pixel_bits = 16; image_rows = 1080; rows_per_wire = 1;
      scan_sel = SCAN_PROGRESSIVE;
      clear_packet_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings.
      // A four-byte segment at the top left of the frame.
      add_row(8'h00, 12, 0); add_row(8'h00, 12, 0);
      add_row(8'h00, 12, 0); add_row(8'h04, 12, 0); add_row(8'h00, 12, 0);
      add_row(8'h00, 12, 0); add_row(8'h00, 12, 0); add_row(8'h00, 12, 0);
      add_row(8'hAA, 12, 0, 1, 0); add_row(8'hBB, 12, 0, 1, 1);
      add_row(8'hCC, 12, 0, 1, 2); add_row(8'hFF, 12, 1, 1, 3);
      // A payload too short to hold any header.
      add_row(8'h5A, 2, 0); add_row(8'hA5, 2, 1);
      // A header whose length overruns the payload: the packet stops.
      add_row(8'hFF, 9, 0); add_row(8'hFF, 9, 0);
      add_row(8'hFF, 9, 0); add_row(8'hFF, 9, 0); add_row(8'hFF, 9, 0);
      add_row(8'hFF, 9, 0); add_row(8'h80, 9, 0); add_row(8'hFF, 9, 0);
      add_row(8'h11, 9, 1);
      // An empty payload ignores everything.
      add_row(8'h00, 0, 1);
      use_typed = 1'b1;
      foreach (dir_rows[i]) begin
         typed_has_write = dir_rows[i].has_write;
         typed_write = '{write_address: dir_rows[i].addr, write_data: dir_rows[i].b};
         send_request(dir_rows[i].b, dir_rows[i].plen, dir_rows[i].last);
      end
      wait_for_drain();
      use_typed = 1'b0;

      // Random part: each setting gets its share of requests; the first and the
      // last settings push line width and frame height to opposite extremes.
      random_base = requests_sent;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            write_register(CSR_BYTES_PER_LINE, 1);
            write_register(CSR_BITS_PER_PIXEL, 1);
            write_register(CSR_FRAME_HEIGHT, 32767);
            write_register(CSR_ROWS_PER_SRD, 1);
            write_register(CSR_SCAN_MODE, SCAN_PROGRESSIVE);
         end else if (ph == NUM_PHASES - 1) begin
            write_register(CSR_BYTES_PER_LINE, 65535);
            write_register(CSR_BITS_PER_PIXEL, 64);
            write_register(CSR_FRAME_HEIGHT, 1);
            write_register(CSR_ROWS_PER_SRD, 2);
            write_register(CSR_SCAN_MODE, SCAN_PSF);
         end else begin
            write_register(CSR_BYTES_PER_LINE, $urandom_range(1, 400));
            write_register(CSR_BITS_PER_PIXEL, $urandom_range(1, 64));
            write_register(CSR_FRAME_HEIGHT, $urandom_range(1, 200));
            write_register(CSR_ROWS_PER_SRD, $urandom_range(1, 3));
            write_register(CSR_SCAN_MODE, $urandom_range(0, 3));
         end
         quiet = (ph == NUM_PHASES - 1);
         phase_goal = random_base + (ph + 1) * TARGET_ITEMS / NUM_PHASES;
         while (requests_sent < phase_goal) begin
            send_random_packet();
            // Once in a while the sender holds off until everything owed has come.
            if (!quiet && $urandom_range(0, 15) == 0) begin
               req_if.valid <= 1'b0;
               while (pending_writes.size() != 0) @(negedge clock);
            end
         end
         wait_for_drain();
      end

      $display("Sent %0d requests in %0d packets over %0d register settings; %0d writes seen.",
               requests_sent, packets_sent, NUM_PHASES + 1, writes_seen);
      $display("Sender idled %0d cycles; overruns, short payloads and noise were mixed in.",
               idle_cycles);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/rvrd_pkg.sv
rtl/rvrd_chan_if.sv
rtl/rvrd_front.sv
rtl/rvrd_addr.sv
rtl/rvrd_queue.sv
rtl/rvrd_back.sv
rtl/raw_video_rtp_depacketizer.sv
tb/raw_video_rtp_depacketizer_tb.sv
